>>> rtl/thermal_fan_duty_controller_top_macros.svh
// Assertion macros used by the checker file of the fan duty controller.
`ifndef THERMAL_FAN_DUTY_CONTROLLER_TOP_MACROS_SVH
`define THERMAL_FAN_DUTY_CONTROLLER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFDC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFDC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tfdc_pkg.sv
`default_nettype none

package tfdc_pkg;

    // Defaults of the top-level parameters.
    localparam int FRAC_BITS_DEF       = 8;
    localparam int TICKS_PER_ROUND_DEF = 60;
    localparam int SAMPLE_EVERY_DEF    = 30;

    // Fixed field widths.
    localparam int TEMP_W     = 8;
    localparam int LEVEL_W    = 3;
    localparam int HYST_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 8;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_DUTY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_FLOOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_BAND1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_BAND2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_BAND3   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CEILING = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS   = 3'd6;

    // Register reset values.
    localparam logic [LEVEL_W-1:0] RST_MANUAL_DUTY  = 3'd0;
    localparam logic [TEMP_W-1:0]  RST_TEMP_FLOOR   = 8'd70;
    localparam logic [TEMP_W-1:0]  RST_TEMP_BAND1   = 8'd76;
    localparam logic [TEMP_W-1:0]  RST_TEMP_BAND2   = 8'd82;
    localparam logic [TEMP_W-1:0]  RST_TEMP_BAND3   = 8'd88;
    localparam logic [TEMP_W-1:0]  RST_TEMP_CEILING = 8'd94;
    localparam logic [HYST_W-1:0]  RST_HYSTERESIS   = 5'd3;

    // Duty levels and their reported codes.
    localparam logic [LEVEL_W-1:0] LVL_FULL = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_OFF  = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_DIV2 = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_DIV3 = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_DIV4 = 3'd4;
    localparam logic [LEVEL_W-1:0] LVL_DIV5 = 3'd5;
    localparam logic [LEVEL_W-1:0] LVL_AUTO = 3'd0;

    localparam logic [LEVEL_W-1:0] REPORT_OFF  = 3'd0;
    localparam logic [LEVEL_W-1:0] REPORT_FULL = 3'd5;

    typedef struct packed {
        logic [LEVEL_W-1:0] manual_duty;
        logic [TEMP_W-1:0]  temp_floor;
        logic [TEMP_W-1:0]  temp_band1;
        logic [TEMP_W-1:0]  temp_band2;
        logic [TEMP_W-1:0]  temp_band3;
        logic [TEMP_W-1:0]  temp_ceiling;
        logic [HYST_W-1:0]  hysteresis;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_COR_A,
        ST_COR_B,
        ST_LEVEL,
        ST_FAN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic seed;
        logic mul_b;
        logic upd_a;
        logic upd_b;
        logic level;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sample_now;
        logic seed_now;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/tfdc_cfg_regs.sv
`default_nettype none

module tfdc_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [tfdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tfdc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output tfdc_pkg::cfg_t                      cfg
);
    import tfdc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes to an unknown index fall through and leave every register alone.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MANUAL_DUTY:  cfg_next.manual_duty  = cfg_wdata[LEVEL_W-1:0];
                REG_TEMP_FLOOR:   cfg_next.temp_floor   = cfg_wdata[TEMP_W-1:0];
                REG_TEMP_BAND1:   cfg_next.temp_band1   = cfg_wdata[TEMP_W-1:0];
                REG_TEMP_BAND2:   cfg_next.temp_band2   = cfg_wdata[TEMP_W-1:0];
                REG_TEMP_BAND3:   cfg_next.temp_band3   = cfg_wdata[TEMP_W-1:0];
                REG_TEMP_CEILING: cfg_next.temp_ceiling = cfg_wdata[TEMP_W-1:0];
                REG_HYSTERESIS:   cfg_next.hysteresis   = cfg_wdata[HYST_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.manual_duty  <= RST_MANUAL_DUTY;
            cfg_reg.temp_floor   <= RST_TEMP_FLOOR;
            cfg_reg.temp_band1   <= RST_TEMP_BAND1;
            cfg_reg.temp_band2   <= RST_TEMP_BAND2;
            cfg_reg.temp_band3   <= RST_TEMP_BAND3;
            cfg_reg.temp_ceiling <= RST_TEMP_CEILING;
            cfg_reg.hysteresis   <= RST_HYSTERESIS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/tfdc_ctrl.sv
`default_nettype none

module tfdc_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  tfdc_pkg::stat_t  stat,
    output tfdc_pkg::cmd_t   cmd
);
    import tfdc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!stat.sample_now)
                    begin
                        state_next = ST_FAN;
                    end
                    else if (stat.seed_now)
                    begin
                        // The first sample loads the averages directly.
                        cmd.seed   = 1'b1;
                        state_next = ST_LEVEL;
                    end
                    else
                    begin
                        state_next = ST_MUL_A;
                    end
                end
            end
            ST_MUL_A:
            begin
                state_next = ST_COR_A;
            end
            ST_COR_A:
            begin
                // The multiplier takes the second sensor while the first is corrected.
                cmd.upd_a  = 1'b1;
                cmd.mul_b  = 1'b1;
                state_next = ST_COR_B;
            end
            ST_COR_B:
            begin
                cmd.upd_b  = 1'b1;
                state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                cmd.level  = 1'b1;
                state_next = ST_FAN;
            end
            ST_FAN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/tfdc_dpath.sv
`default_nettype none

module tfdc_dpath #(
    parameter int FRAC_BITS       = tfdc_pkg::FRAC_BITS_DEF,
    parameter int TICKS_PER_ROUND = tfdc_pkg::TICKS_PER_ROUND_DEF,
    parameter int SAMPLE_EVERY    = tfdc_pkg::SAMPLE_EVERY_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  tfdc_pkg::cfg_t                  cfg,
    input  tfdc_pkg::cmd_t                  cmd,
    output tfdc_pkg::stat_t                 stat,
    input  wire logic                       in_mode,
    input  wire logic [tfdc_pkg::TEMP_W-1:0] in_sensor_a,
    input  wire logic [tfdc_pkg::TEMP_W-1:0] in_sensor_b,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output logic                            out_fan_on,
    output logic                            out_fan_changed,
    output logic [tfdc_pkg::LEVEL_W-1:0]    out_level_report,
    output logic                            out_sampled
);
    import tfdc_pkg::*;

    localparam int AVG_W  = TEMP_W + FRAC_BITS;
    localparam int SUM_W  = AVG_W + 1;
    localparam int X_W    = AVG_W + 3;
    localparam int RCP_K  = X_W + 2;
    localparam int PROD_W = 2 * X_W;
    localparam logic [X_W-1:0] RECIP = X_W'((64'd1 << RCP_K) / 64'd5);
    localparam int TICK_W = $clog2(TICKS_PER_ROUND);
    localparam int PH_W   = (SAMPLE_EVERY > 1) ? $clog2(SAMPLE_EVERY) : 1;
    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICKS_PER_ROUND - 1);
    localparam logic [PH_W-1:0]   PH_LAST   = PH_W'(SAMPLE_EVERY - 1);

    logic [AVG_W-1:0]   avg_a_reg, avg_a_next;
    logic [AVG_W-1:0]   avg_b_reg, avg_b_next;
    logic               seeded_reg, seeded_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [PH_W-1:0]    phase_reg, phase_next;
    logic [1:0]         mod3_reg, mod3_next;
    logic [1:0]         mod4_reg, mod4_next;
    logic [2:0]         mod5_reg, mod5_next;
    logic               fan_last_reg, fan_last_next;
    logic               fan_known_reg, fan_known_next;
    logic               sampled_reg, sampled_next;
    logic               out_valid_reg, out_valid_next;

    logic [TEMP_W-1:0]  sa_reg;
    logic [TEMP_W-1:0]  sb_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               out_fan_reg;
    logic               out_chg_reg;
    logic [LEVEL_W-1:0] out_rep_reg;
    logic               out_smp_reg;

    logic [X_W-1:0]     x_a;
    logic [X_W-1:0]     x_b;
    logic [X_W-1:0]     x_mul;
    logic [X_W-1:0]     x_cor;
    logic [AVG_W-1:0]   q_est;
    logic [X_W-1:0]     five_q;
    logic [X_W-1:0]     rem;
    logic [AVG_W-1:0]   q_fix;

    logic [SUM_W-1:0]   sum;
    logic [TEMP_W-1:0]  thr [5];
    logic [TEMP_W:0]    diff [5];
    logic [4:0]         above;
    logic [4:0]         below_hyst;
    logic               below_ceiling;
    logic [LEVEL_W-1:0] manual;
    logic [LEVEL_W-1:0] level_sel;

    logic               fan;
    logic               changed;
    logic [LEVEL_W-1:0] report;

    assign stat.sample_now = in_mode || (phase_reg == '0);
    assign stat.seed_now   = !(seeded_reg || in_mode);
    assign stat.out_free   = !out_valid_reg || out_ready;

    // Divide by five: multiply by a scaled reciprocal, then one correction step,
    // since the estimate never falls more than one below the true quotient.
    assign x_a   = {1'b0, avg_a_reg, 2'b00} + {3'b000, sa_reg, {FRAC_BITS{1'b0}}};
    assign x_b   = {1'b0, avg_b_reg, 2'b00} + {3'b000, sb_reg, {FRAC_BITS{1'b0}}};
    assign x_mul = cmd.mul_b ? x_b : x_a;
    assign x_cor = cmd.upd_b ? x_b : x_a;

    assign q_est  = prod_reg[RCP_K +: AVG_W];
    assign five_q = X_W'({q_est, 2'b00}) + X_W'(q_est);
    assign rem    = x_cor - five_q;
    assign q_fix  = q_est + AVG_W'(rem >= X_W'(5));

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(x_mul) * PROD_W'(RECIP);
        if (cmd.accept)
        begin
            sa_reg <= in_sensor_a;
            sb_reg <= in_sensor_b;
        end
        if (cmd.finish)
        begin
            out_fan_reg <= fan;
            out_chg_reg <= changed;
            out_rep_reg <= report;
            out_smp_reg <= sampled_reg;
        end
    end

    // Band selection on the sum of the two averages, which carries one more
    // fraction bit than each average, so every comparison is exact.
    assign sum    = {1'b0, avg_a_reg} + {1'b0, avg_b_reg};
    assign thr[0] = cfg.temp_floor;
    assign thr[1] = cfg.temp_band1;
    assign thr[2] = cfg.temp_band2;
    assign thr[3] = cfg.temp_band3;
    assign thr[4] = cfg.temp_ceiling;

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            diff[i]       = {1'b0, thr[i]} - {{(TEMP_W + 1 - HYST_W){1'b0}}, cfg.hysteresis};
            above[i]      = sum > {thr[i], {(FRAC_BITS + 1){1'b0}}};
            // A limit that went negative can never be undercut.
            below_hyst[i] = !diff[i][TEMP_W] &&
                            (sum < {diff[i][TEMP_W-1:0], {(FRAC_BITS + 1){1'b0}}});
        end
    end

    assign below_ceiling = sum < {cfg.temp_ceiling, {(FRAC_BITS + 1){1'b0}}};
    assign manual = (cfg.manual_duty > LVL_DIV5) ? LVL_AUTO : cfg.manual_duty;

    always_comb
    begin
        if ((manual != LVL_AUTO) && below_ceiling)
        begin
            level_sel = manual;
        end
        else if (below_hyst[0])
        begin
            level_sel = LVL_OFF;
        end
        else if (above[0] && below_hyst[1])
        begin
            level_sel = LVL_DIV2;
        end
        else if (above[1] && below_hyst[2])
        begin
            level_sel = LVL_DIV3;
        end
        else if (above[2] && below_hyst[3])
        begin
            level_sel = LVL_DIV4;
        end
        else if (above[3] && below_hyst[4])
        begin
            level_sel = LVL_DIV5;
        end
        else if (above[4])
        begin
            level_sel = LVL_FULL;
        end
        else
        begin
            level_sel = level_reg;
        end
    end

    // The residues of the tick count modulo three, four and five run as
    // counters of their own; they clear together with the tick count.
    always_comb
    begin
        case (level_reg)
            LVL_FULL: fan = 1'b1;
            LVL_OFF:  fan = 1'b0;
            LVL_DIV2: fan = mod4_reg[0];
            LVL_DIV3: fan = (mod3_reg != 2'd0);
            LVL_DIV4: fan = (mod4_reg != 2'd0);
            LVL_DIV5: fan = (mod5_reg != 3'd0);
            default:  fan = 1'b0;
        endcase
    end

    assign changed = !fan_known_reg || (fan != fan_last_reg);
    assign report  = (level_reg == LVL_FULL) ? REPORT_FULL : (level_reg - LVL_OFF);

    always_comb
    begin
        avg_a_next     = avg_a_reg;
        avg_b_next     = avg_b_reg;
        seeded_next    = seeded_reg;
        level_next     = level_reg;
        tick_next      = tick_reg;
        phase_next     = phase_reg;
        mod3_next      = mod3_reg;
        mod4_next      = mod4_reg;
        mod5_next      = mod5_reg;
        fan_last_next  = fan_last_reg;
        fan_known_next = fan_known_reg;
        sampled_next   = sampled_reg;
        out_valid_next = out_valid_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.accept)
        begin
            sampled_next = stat.sample_now;
            if (in_mode)
            begin
                // Restart: the averages count as started and are never reseeded.
                tick_next      = '0;
                phase_next     = '0;
                mod3_next      = '0;
                mod4_next      = '0;
                mod5_next      = '0;
                fan_known_next = 1'b0;
                seeded_next    = 1'b1;
            end
        end

        if (cmd.seed)
        begin
            avg_a_next  = {in_sensor_a, {FRAC_BITS{1'b0}}};
            avg_b_next  = {in_sensor_b, {FRAC_BITS{1'b0}}};
            seeded_next = 1'b1;
        end

        if (cmd.upd_a)
        begin
            avg_a_next = q_fix;
        end

        if (cmd.upd_b)
        begin
            avg_b_next = q_fix;
        end

        if (cmd.level)
        begin
            level_next = level_sel;
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            fan_last_next  = fan;
            fan_known_next = 1'b1;
            if (tick_reg == TICK_LAST)
            begin
                tick_next  = '0;
                phase_next = '0;
                mod3_next  = '0;
                mod4_next  = '0;
                mod5_next  = '0;
            end
            else
            begin
                tick_next  = tick_reg + 1'b1;
                phase_next = (phase_reg == PH_LAST) ? '0 : (phase_reg + 1'b1);
                mod3_next  = (mod3_reg == 2'd2) ? 2'd0 : (mod3_reg + 2'd1);
                mod4_next  = mod4_reg + 2'd1;
                mod5_next  = (mod5_reg == 3'd4) ? 3'd0 : (mod5_reg + 3'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_a_reg     <= '0;
            avg_b_reg     <= '0;
            seeded_reg    <= 1'b0;
            level_reg     <= LVL_OFF;
            tick_reg      <= '0;
            phase_reg     <= '0;
            mod3_reg      <= '0;
            mod4_reg      <= '0;
            mod5_reg      <= '0;
            fan_last_reg  <= 1'b0;
            fan_known_reg <= 1'b0;
            sampled_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            avg_a_reg     <= avg_a_next;
            avg_b_reg     <= avg_b_next;
            seeded_reg    <= seeded_next;
            level_reg     <= level_next;
            tick_reg      <= tick_next;
            phase_reg     <= phase_next;
            mod3_reg      <= mod3_next;
            mod4_reg      <= mod4_next;
            mod5_reg      <= mod5_next;
            fan_last_reg  <= fan_last_next;
            fan_known_reg <= fan_known_next;
            sampled_reg   <= sampled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_fan_on       = out_fan_reg;
    assign out_fan_changed  = out_chg_reg;
    assign out_level_report = out_rep_reg;
    assign out_sampled      = out_smp_reg;

endmodule

`default_nettype wire

>>> rtl/thermal_fan_duty_controller_top.sv
// Channel   Direction  Ports                               Contents
// s_        in         s_tvalid s_tready s_tdata s_tuser   one tick with two sensor readings
// m_        out        m_tvalid m_tready m_tdata           fan drive and duty report of a tick
// cfg_      in         cfg_we cfg_index cfg_wdata          threshold and manual duty registers
//
// A tick that takes no sample goes from acceptance to the fan decision; a sampling
// tick adds the level choice, and one that updates rather than seeds the averages
// adds MUL_A, COR_A and COR_B too, as one divide-by-five multiplier serves both in turn.
// Reset is asynchronous and active low; the state registers return to their reset values.
// A finished item waits in the output register while the next item is accepted;
// only when that next item needs the output register does the block stall.
`default_nettype none

module thermal_fan_duty_controller_top #(
    parameter int FRAC_BITS       = tfdc_pkg::FRAC_BITS_DEF,
    parameter int TICKS_PER_ROUND = tfdc_pkg::TICKS_PER_ROUND_DEF,
    parameter int SAMPLE_EVERY    = tfdc_pkg::SAMPLE_EVERY_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // s_tdata, from bit 0: sensor_a[7:0], sensor_b[7:0]
    input  wire logic [tfdc_pkg::IN_DATA_W-1:0]  s_tdata,
    // s_tuser, from bit 0: mode (1 restarts the tick count before the tick)
    input  wire logic [tfdc_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // m_tdata, from bit 0: fan_on, fan_changed, level_report[2:0], sampled, two zero bits
    output logic [tfdc_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [tfdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tfdc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tfdc_pkg::*;

    cfg_t               cfg;
    cmd_t               cmd;
    stat_t              stat;
    logic               fan_on;
    logic               fan_changed;
    logic [LEVEL_W-1:0] level_report;
    logic               sampled;

    // Registers are to be written only while no item is in flight; the block does not check.
    tfdc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The sequencer steps each item from acceptance to the fan decision; a sampling
    // item also passes through averaging and the level choice.
    tfdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the averages, the duty level, the tick counters and
    // the output register.
    tfdc_dpath #(
        .FRAC_BITS       (FRAC_BITS),
        .TICKS_PER_ROUND (TICKS_PER_ROUND),
        .SAMPLE_EVERY    (SAMPLE_EVERY)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .stat             (stat),
        .in_mode          (s_tuser[0]),
        .in_sensor_a      (s_tdata[TEMP_W-1:0]),
        .in_sensor_b      (s_tdata[2*TEMP_W-1:TEMP_W]),
        .out_ready        (m_tready),
        .out_valid        (m_tvalid),
        .out_fan_on       (fan_on),
        .out_fan_changed  (fan_changed),
        .out_level_report (level_report),
        .out_sampled      (sampled)
    );

    assign m_tdata = {2'b00, sampled, level_report, fan_changed, fan_on};

endmodule

`default_nettype wire

>>> rtl/tfdc_checker.sv
`default_nettype none
`include "thermal_fan_duty_controller_top_macros.svh"

module tfdc_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [tfdc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import tfdc_pkg::*;

    // A result that waits keeps its value.
    `TFDC_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output item changed while stalled")

    // Items are never accepted back to back.
    `TFDC_ASSERT_NXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready, "input accepted in consecutive cycles")

    // Reported duty stays within the six levels.
    `TFDC_ASSERT_IMP(a_report_range, clk, rst_n, m_tvalid, m_tdata[4:2] <= REPORT_FULL, "level report out of range")

    // The off level never drives the fan.
    `TFDC_ASSERT_IMP(a_off_level, clk, rst_n, m_tvalid && (m_tdata[4:2] == REPORT_OFF), !m_tdata[0], "fan on at the off level")

    // The full level always drives the fan.
    `TFDC_ASSERT_IMP(a_full_level, clk, rst_n, m_tvalid && (m_tdata[4:2] == REPORT_FULL), m_tdata[0], "fan off at the full level")

endmodule

bind thermal_fan_duty_controller_top tfdc_checker u_tfdc_checker (.*);

`default_nettype wire
